// ----- hdl/u32u8_pkg.sv -----
// Package: payload types, queue entry type and constants for the UTF-32 to UTF-8 converter.
`default_nettype none

package u32u8_pkg;

	// register map
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;
	localparam logic [0:0] REG_BIG_ENDIAN = 1'b0;

	// code point limits
	localparam logic [31:0] SURR_LO = 32'h0000_d800;
	localparam logic [31:0] SURR_HI = 32'h0000_dfff;
	localparam logic [31:0] LAST_CP = 32'h0010_ffff;
	localparam logic [7:0]  BYTE_MASK = 8'hff;

	// classified-word queue
	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [31:0] data_word;
		logic [2:0]  valid_bytes;
		logic        end_of_string;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       status;
		logic       last_of_run;
	} out_item_t;

	// one classified word: up to four bytes, index of the last one, error flag
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      last_idx;
		logic            err;
	} q_entry_t;

	// handshake bundle for a queue entry
	typedef struct packed {
		logic     valid;
		q_entry_t entry;
	} q_xfer_t;

endpackage

`default_nettype wire

// ----- hdl/utf32_to_utf8_converter_top.sv -----
// Top level of the UTF-32 to UTF-8 converter: config register, front end, queue, back end.
`default_nettype none

// Converts a UTF-32 string, one 32-bit word per input transaction, into a stream of UTF-8
// bytes, one byte per output transaction with last_of_run set on the final byte of each
// word. Words are assembled little endian, or big endian when big_endian_input (register 0,
// byte address 0) is 1; write it only while the block is idle. A word with fewer than four
// valid bytes, a surrogate (D800-DFFF) or a value above 10FFFF yields one error marker
// (status 1, byte zero) and halts the string: further words give nothing until the word
// marked end_of_string, which clears the halt. Timing: the front end classifies and encodes
// a word in the cycle it is accepted and pushes it into a two-entry queue; the back end
// moves one byte per cycle into the output register while the output is not stalled, a
// word of n bytes (1 to 4) giving n output transactions. When the queue is empty, the first
// byte of an accepted word passes through the queue and then into the output register.
// Input stall rises only when the queue is full; words of a halted string are absorbed at
// one per cycle while the queue is not full and produce no output.
module utf32_to_utf8_converter_top (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// input word channel
	input  wire logic                                 in_valid,
	output      logic                                 in_stall,
	input  wire u32u8_pkg::in_item_t                  in_data,
	// output byte channel
	output      logic                                 out_valid,
	input  wire logic                                 out_stall,
	output      u32u8_pkg::out_item_t                 out_data,
	// APB-style configuration port
	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic [u32u8_pkg::PADDR_W-1:0]        paddr,
	input  wire logic [u32u8_pkg::PDATA_W-1:0]        pwdata,
	output      logic [u32u8_pkg::PDATA_W-1:0]        prdata,
	output      logic                                 pready
);
	import u32u8_pkg::*;

	logic    msb_first_q;
	logic    cfg_wr;
	logic    q_full;
	logic    pop;
	q_xfer_t push;
	q_xfer_t head;

	// Register file: a single bit at byte address 0; the word index is paddr[2].
	// Writes to any other index are dropped, reads of them return zero.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msb_first_q <= 1'b0;
		end else if (cfg_wr && (paddr[PADDR_W-1] == REG_BIG_ENDIAN)) begin
			msb_first_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[PADDR_W-1] == REG_BIG_ENDIAN) begin
			prdata[0] = msb_first_q;
		end
	end

	// front end: accept, check, encode, track halt
	u32u8_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.msb_first (msb_first_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.push      (push),
		.q_full    (q_full)
	);

	// decouples word acceptance from byte emission
	u32u8_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.head   (head),
		.pop    (pop)
	);

	// back end: one byte per output transaction
	u32u8_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

// ----- hdl/u32u8_front.sv -----
// Front end: accepts input words, checks them, encodes UTF-8 bytes, tracks the halt state.
`default_nettype none

module u32u8_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 msb_first,
	input  wire logic                 in_valid,
	output      logic                 in_stall,
	input  wire u32u8_pkg::in_item_t  in_data,
	output      u32u8_pkg::q_xfer_t   push,
	input  wire logic                 q_full
);
	import u32u8_pkg::*;

	logic        halted_q;
	logic        accept;
	logic [31:0] cp;
	logic        reject;
	q_entry_t    enc;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	always_comb begin
		if (msb_first) begin
			cp = {in_data.data_word[7:0], in_data.data_word[15:8],
			      in_data.data_word[23:16], in_data.data_word[31:24]};
		end else begin
			cp = in_data.data_word;
		end
	end

	// valid counts 5..7 count as a full word
	assign reject = (in_data.valid_bytes < 3'd4)
	             || ((cp >= SURR_LO) && (cp <= SURR_HI))
	             || (cp > LAST_CP);

	always_comb begin
		enc.bytes    = '0;
		enc.last_idx = 2'd0;
		enc.err      = 1'b0;
		if (reject) begin
			enc.err = 1'b1;
		end else if (cp < 32'h80) begin
			enc.bytes[0] = cp[7:0] & BYTE_MASK;
		end else if (cp < 32'h800) begin
			enc.bytes[0] = {3'b110, cp[10:6]};
			enc.bytes[1] = {2'b10, cp[5:0]};
			enc.last_idx = 2'd1;
		end else if (cp < 32'h1_0000) begin
			enc.bytes[0] = {4'b1110, cp[15:12]};
			enc.bytes[1] = {2'b10, cp[11:6]};
			enc.bytes[2] = {2'b10, cp[5:0]};
			enc.last_idx = 2'd2;
		end else begin
			enc.bytes[0] = {5'b11110, cp[20:18]};
			enc.bytes[1] = {2'b10, cp[17:12]};
			enc.bytes[2] = {2'b10, cp[11:6]};
			enc.bytes[3] = {2'b10, cp[5:0]};
			enc.last_idx = 2'd3;
		end
	end

	assign push.valid = accept && !halted_q;
	assign push.entry = enc;

	// halt after a rejection unless that word closes the string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halted_q <= 1'b0;
		end else if (accept) begin
			if (halted_q) begin
				halted_q <= !in_data.end_of_string;
			end else begin
				halted_q <= reject && !in_data.end_of_string;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hdl/u32u8_queue.sv -----
// Small FIFO of classified words between the front end and the byte serializer.
`default_nettype none

module u32u8_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire u32u8_pkg::q_xfer_t  push,
	output      logic                full,
	output      u32u8_pkg::q_xfer_t  head,
	input  wire logic                pop
);
	import u32u8_pkg::*;

	q_entry_t            mem [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic                do_push;
	logic                do_pop;

	assign full       = (cnt_q == QCNT_W'(QDEPTH));
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && (cnt_q != '0);
	assign head.valid = (cnt_q != '0);
	assign head.entry = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hdl/u32u8_back.sv -----
// Back end: walks the bytes of the head queue entry into the output register.
`default_nettype none

module u32u8_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire u32u8_pkg::q_xfer_t   head,
	output      logic                 pop,
	output      logic                 out_valid,
	input  wire logic                 out_stall,
	output      u32u8_pkg::out_item_t out_data
);
	import u32u8_pkg::*;

	logic [1:0] idx_q;
	logic       out_valid_q;
	out_item_t  out_q;
	logic       load;
	logic       is_last;

	assign load    = !out_valid_q || !out_stall;
	assign is_last = (idx_q == head.entry.last_idx);
	assign pop     = load && head.valid && is_last;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else if (load) begin
			out_valid_q <= head.valid;
			if (head.valid) begin
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && head.valid) begin
			out_q.out_byte    <= head.entry.bytes[idx_q];
			out_q.status      <= head.entry.err;
			out_q.last_of_run <= is_last;
		end
	end

endmodule

`default_nettype wire

// ----- verif/utf8_check_pkg.sv -----
// Scoreboard class: predicts the UTF-8 byte stream and checks the output transactions.
package utf8_check_pkg;

	import u32u8_pkg::*;

	localparam logic ST_BYTE = 1'b0;
	localparam logic ST_ERROR = 1'b1;
	// address 4 decodes to no register
	localparam int unsigned REG_UNUSED = 1;

	class utf8_scoreboard;
		out_item_t expected_bytes[$];
		logic msb_first;
		logic halted;
		int unsigned fails;

		function new();
			msb_first = 1'b0;
			halted = 1'b0;
			fails = 0;
		endfunction

		function void write_reg(input int unsigned index, input logic [31:0] value);
			if (index == REG_BIG_ENDIAN) begin
				msb_first = value[0];
			end
		endfunction

		function int unsigned pending();
			return expected_bytes.size();
		endfunction

		function void push_byte(input logic [7:0] b, input logic st, input logic last);
			out_item_t e;
			e.out_byte = b;
			e.status = st;
			e.last_of_run = last;
			expected_bytes.push_back(e);
		endfunction

		// expected bytes for one accepted input word
		function void note_word(input in_item_t w);
			logic [31:0] cp;
			logic [7:0] enc[4];
			int n;
			if (halted) begin
				if (w.end_of_string) begin
					halted = 1'b0;
				end
				return;
			end
			cp = msb_first ? {w.data_word[7:0], w.data_word[15:8],
				w.data_word[23:16], w.data_word[31:24]} : w.data_word;
			if (w.valid_bytes < 3'd4 || (cp >= SURR_LO && cp <= SURR_HI) || cp > LAST_CP) begin
				push_byte(8'h00, ST_ERROR, 1'b1);
				halted = !w.end_of_string;
				return;
			end
			if (cp < 32'h80) begin
				enc[0] = cp[7:0];
				n = 1;
			end else if (cp < 32'h800) begin
				enc[0] = {3'b110, cp[10:6]};
				enc[1] = {2'b10, cp[5:0]};
				n = 2;
			end else if (cp < 32'h10000) begin
				enc[0] = {4'b1110, cp[15:12]};
				enc[1] = {2'b10, cp[11:6]};
				enc[2] = {2'b10, cp[5:0]};
				n = 3;
			end else begin
				enc[0] = {5'b11110, cp[20:18]};
				enc[1] = {2'b10, cp[17:12]};
				enc[2] = {2'b10, cp[11:6]};
				enc[3] = {2'b10, cp[5:0]};
				n = 4;
			end
			for (int i = 0; i < n; i++) begin
				push_byte(enc[i], ST_BYTE, i == n - 1);
			end
		endfunction

		function void check_byte(input out_item_t got);
			out_item_t e;
			if (expected_bytes.size() == 0) begin
				$error("unexpected output byte %h status %0d last %0d",
					got.out_byte, got.status, got.last_of_run);
				fails++;
				return;
			end
			e = expected_bytes.pop_front();
			if (got.out_byte !== e.out_byte) begin
				$error("out_byte: expected %h, got %h", e.out_byte, got.out_byte);
				fails++;
			end
			if (got.status !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, got.status);
				fails++;
			end
			if (got.last_of_run !== e.last_of_run) begin
				$error("last_of_run: expected %0d, got %0d", e.last_of_run, got.last_of_run);
				fails++;
			end
		endfunction
	endclass

endpackage

// ----- verif/utf32_to_utf8_converter_top_test.sv -----
// Testbench top: drives UTF-32 words and config writes, checks the UTF-8 byte stream.
module utf32_to_utf8_converter_top_test;

	timeunit 1ns;
	timeprecision 1ps;

	import u32u8_pkg::*;
	import utf8_check_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;

	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	// idle knobs, changed only between phases
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	// a nonzero value asks the receiver for one long hold-off, its length set by the value
	int unsigned hold_request = 0;
	// byte order the stimulus packs code points in; tracks the register
	logic be_mode = 1'b0;

	utf8_scoreboard sb = new();

	utf32_to_utf8_converter_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		forever begin
			#10 clk = ~clk;
		end
	end

	// Monitors sample at the edge, before the driver's nonblocking updates land,
	// so both see exactly the values that the block itself saw.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			sb.note_word(in_data);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_byte(out_data);
		end
	end

	// Receiver: random stall per cycle, or one long hold-off on request. The
	// hold-off lets the two-entry queue fill so that in_stall has to rise.
	initial begin
		int unsigned hold_len;
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				out_stall <= 1'b1;
				hold_len = hold_request;
				hold_request = 0;
				repeat (hold_len) @(posedge clk);
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// Lay a code point out in memory order for the current byte order.
	function automatic logic [31:0] word_of(input logic [31:0] cp);
		return be_mode ? {cp[7:0], cp[15:8], cp[23:16], cp[31:24]} : cp;
	endfunction

	// Any legal scalar value, spread evenly over the four encoded lengths.
	function automatic logic [31:0] rand_cp();
		logic [31:0] cp;
		case ($urandom_range(3))
			0: cp = $urandom_range(32'h7f);
			1: cp = $urandom_range(32'h7ff, 32'h80);
			2: begin
				cp = $urandom_range(32'hffff, 32'h800);
				// move surrogates up into F800-FFFF
				if (cp >= SURR_LO && cp <= SURR_HI) begin
					cp = cp ^ 32'h2000;
				end
			end
			default: cp = $urandom_range(LAST_CP, 32'h10000);
		endcase
		return cp;
	endfunction

	// One input transaction; returns at the edge that accepts it.
	task automatic send(input logic [31:0] word, input logic [2:0] nvalid, input logic eos);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{data_word: word, valid_bytes: nvalid, end_of_string: eos};
		do @(posedge clk); while (in_stall);
	endtask

	// Wait until every predicted byte has arrived, plus the pipeline depth, so
	// that trailing halted words have been absorbed too.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Setup cycle, then access cycle; the register takes the value at the edge
	// where penable is high and pready answers.
	task automatic apb_write(input int unsigned index, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(4 * index);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		sb.write_reg(index, value);
		if (index == REG_BIG_ENDIAN) begin
			be_mode = value[0];
		end
	endtask

	// Mostly well-formed strings of 1 to 6 words with random content; about one
	// word in eight is noise: raw 32-bit garbage, a surrogate, a value above the
	// code space, or a truncated tail. Strings therefore halt part way often.
	task automatic send_strings(input int unsigned count);
		int unsigned sent;
		int unsigned len;
		logic [31:0] word;
		logic [2:0] nvalid;
		sent = 0;
		while (sent < count) begin
			len = $urandom_range(6, 1);
			for (int i = 0; i < len && sent < count; i++) begin
				nvalid = 3'd4;
				if ($urandom_range(99) < 12) begin
					case ($urandom_range(3))
						0: begin
							word = $urandom;
							nvalid = 3'($urandom_range(7));
						end
						1: word = word_of($urandom_range(SURR_HI, SURR_LO));
						2: word = word_of($urandom_range(32'hffff_ffff, LAST_CP + 1));
						default: begin
							word = word_of(rand_cp());
							nvalid = 3'($urandom_range(3));
						end
					endcase
				end else begin
					word = word_of(rand_cp());
					// counts above four behave as a full word
					if ($urandom_range(9) == 0) begin
						nvalid = 3'($urandom_range(7, 5));
					end
				end
				send(word, nvalid, i == len - 1 || sent == count - 1);
				sent++;
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apb_write(REG_BIG_ENDIAN, 32'h0);

		// Directed, little endian: each boundary of the encoded length.
		send(word_of(32'h0), 3'd4, 1'b0);
		send(word_of(32'h7f), 3'd4, 1'b0);
		send(word_of(32'h80), 3'd4, 1'b0);
		send(word_of(32'h7ff), 3'd4, 1'b0);
		send(word_of(32'h800), 3'd4, 1'b0);
		send(word_of(32'hd7ff), 3'd4, 1'b0);
		send(word_of(32'he000), 3'd4, 1'b0);
		send(word_of(32'hffff), 3'd4, 1'b0);
		send(word_of(32'h10000), 3'd4, 1'b0);
		send(word_of(LAST_CP), 3'd4, 1'b1);
		// low surrogate halts; the next two words are swallowed, the second
		// one ends the string and clears the halt
		send(word_of(SURR_LO), 3'd4, 1'b0);
		send(word_of(32'h41), 3'd4, 1'b0);
		send(word_of(32'h42), 3'd4, 1'b1);
		// rejection on an end-of-string word leaves the next string clean
		send(word_of(SURR_HI), 3'd4, 1'b1);
		send(word_of(32'h41), 3'd4, 1'b1);
		// just past the code space, halted string closed by a quiet word
		send(word_of(LAST_CP + 1), 3'd4, 1'b0);
		send(word_of(32'h43), 3'd4, 1'b1);
		send(32'hffff_ffff, 3'd4, 1'b1);
		// truncated tails, every short count
		send(word_of(32'h41), 3'd0, 1'b1);
		send(word_of(32'h41), 3'd1, 1'b1);
		send(word_of(32'h41), 3'd2, 1'b1);
		send(word_of(32'h41), 3'd3, 1'b1);
		// oversized counts act as complete words
		send(word_of(32'h24), 3'd5, 1'b0);
		send(word_of(32'h20ac), 3'd6, 1'b0);
		send(word_of(32'h1f600), 3'd7, 1'b1);
		drain();

		// A write beyond register 0 must not touch the byte order: 0x41 in
		// memory still reads as 'A', not as 0x41000000.
		apb_write(REG_UNUSED, 32'h1);
		send(32'h41, 3'd4, 1'b1);
		drain();

		// Big endian, directed: same memory word now rejected, then valid text.
		apb_write(REG_BIG_ENDIAN, 32'h1);
		send(32'h41, 3'd4, 1'b1);
		send(word_of(32'h1f600), 3'd4, 1'b0);
		send(word_of(LAST_CP), 3'd4, 1'b1);
		drain();

		// Phase 1: no idling, with one long receiver hold-off up front while the
		// sender keeps pushing, so the input stalls.
		apb_write(REG_BIG_ENDIAN, 32'h0);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_request = 150;
		send_strings(60);
		drain();

		// Phase 2: sparse sender.
		apb_write(REG_BIG_ENDIAN, 32'h1);
		send_idle_pct = 80;
		recv_stall_pct = 0;
		send_strings(60);
		drain();

		// Phase 3: slow receiver.
		apb_write(REG_BIG_ENDIAN, 32'h0);
		send_idle_pct = 0;
		recv_stall_pct = 80;
		send_strings(60);
		drain();

		// Phase 4: light idling on both sides; the sender pauses half way until
		// every pending byte is out.
		apb_write(REG_BIG_ENDIAN, 32'h1);
		send_idle_pct = 13;
		recv_stall_pct = 13;
		send_strings(30);
		drain();
		send_strings(30);
		drain();

		if (sb.fails == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#5ms;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
